### rtl/empa_pkg.sv
// Shared widths, divider op codes and the control/status bundles
// exchanged between the sequencer and the datapath of the angle unit.
// No dependencies.
package empa_pkg;

	localparam int CNT_W  = 16;   // quadrature counter width
	localparam int ANG_W  = 16;   // angle turn-fraction width
	localparam int RES_W  = 15;   // counts per turn
	localparam int PP_W   = 7;    // pole pairs
	localparam int OFS_W  = 16;   // angle offset
	localparam int STEP_W = 4;    // divider step counter, CNT_W steps

	localparam logic [CNT_W-1:0] MID_SCALE = 16'h7FFF;

	// divider operations
	localparam logic [1:0] OP_POS  = 2'd0;  // |count - mid| mod R
	localparam logic [1:0] OP_ELEC = 2'd1;  // R / P
	localparam logic [1:0] OP_MOD  = 2'd2;  // pos mod E
	localparam logic [1:0] OP_FRAC = 2'd3;  // (m << 16) / E

	typedef struct packed {
		logic       init_res;
		logic       init_reload;
		logic       init_valid;
		logic       div_load;
		logic [1:0] div_op;
		logic       div_step;
		logic       pos_done;
		logic       elec_done;
		logic       ang_frac;
		logic       ang_offs;
		logic       publish;
	} empa_cmd_t;

	typedef struct packed {
		logic res_zero;
		logic pp_zero;
		logic quot_zero;
		logic out_free;
	} empa_stat_t;

endpackage

### rtl/empa_ctrl.sv
// Sequencer of the angle unit: marker state, item intake and the order
// of divider runs. Depends on empa_pkg.
module empa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_sample,
	input  logic                in_busy,
	input  empa_pkg::empa_stat_t stat,
	output empa_pkg::empa_cmd_t  cmd
);
	import empa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [1:0]        op_q, op_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              marked_q, marked_d;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		op_d     = op_q;
		cnt_d    = cnt_q;
		marked_d = marked_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.init_res = 1'b1;
					state_d      = ST_DONE;
					if (!in_sample) begin
						cmd.init_reload = marked_q || in_busy;
						if (in_busy)
							marked_d = 1'b1;
					end else if (marked_q) begin
						cmd.init_valid = 1'b1;
						if (stat.res_zero) begin
							cmd.ang_offs = 1'b1;
						end else begin
							cmd.div_load = 1'b1;
							cmd.div_op   = OP_POS;
							op_d         = OP_POS;
							cnt_d        = '0;
							state_d      = ST_RUN;
						end
					end
				end
			end
			ST_RUN: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == {STEP_W{1'b1}})
					state_d = ST_END;
			end
			ST_END: begin
				cnt_d = '0;
				unique case (op_q)
					OP_POS: begin
						cmd.pos_done = 1'b1;
						if (stat.pp_zero) begin
							cmd.ang_offs = 1'b1;
							state_d      = ST_DONE;
						end else begin
							cmd.div_load = 1'b1;
							cmd.div_op   = OP_ELEC;
							op_d         = OP_ELEC;
							state_d      = ST_RUN;
						end
					end
					OP_ELEC: begin
						cmd.elec_done = 1'b1;
						if (stat.quot_zero) begin
							cmd.ang_offs = 1'b1;
							state_d      = ST_DONE;
						end else begin
							cmd.div_load = 1'b1;
							cmd.div_op   = OP_MOD;
							op_d         = OP_MOD;
							state_d      = ST_RUN;
						end
					end
					OP_MOD: begin
						cmd.div_load = 1'b1;
						cmd.div_op   = OP_FRAC;
						op_d         = OP_FRAC;
						state_d      = ST_RUN;
					end
					OP_FRAC: begin
						cmd.ang_frac = 1'b1;
						state_d      = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_POS;
			cnt_q    <= '0;
			marked_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			cnt_q    <= cnt_d;
			marked_q <= marked_d;
		end
	end

endmodule

### rtl/empa_dp.sv
// Datapath of the angle unit: config registers, shared restoring divider,
// result and output registers. Depends on empa_pkg.
module empa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [empa_pkg::OFS_W-1:0]    cfg_data,
	input  logic [empa_pkg::CNT_W-1:0]    count_value,
	input  empa_pkg::empa_cmd_t           cmd,
	output empa_pkg::empa_stat_t          stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [39:0]                   out_data
);
	import empa_pkg::*;

	localparam logic [1:0] REG_RES = 2'd0;
	localparam logic [1:0] REG_REV = 2'd1;
	localparam logic [1:0] REG_PP  = 2'd2;
	localparam logic [1:0] REG_OFS = 2'd3;

	logic [RES_W-1:0] res_q;
	logic             rev_q;
	logic [PP_W-1:0]  pp_q;
	logic [OFS_W-1:0] ofs_q;

	logic             neg_q;
	logic [RES_W-1:0] rem_q;
	logic [CNT_W-1:0] dvd_q;
	logic [RES_W-1:0] dvs_q;
	logic [RES_W-1:0] elec_q;

	logic             reload_q, valid_q;
	logic [RES_W-1:0] pos_q;
	logic [ANG_W-1:0] angle_q;
	logic             oval_q;
	logic [39:0]      odata_q;

	logic [CNT_W:0]   diff, mag;
	logic [RES_W:0]   rem_sh, rem_sub;
	logic             ge;
	logic [RES_W-1:0] euc, pos_new;

	// signed distance from mid-scale and its magnitude
	assign diff = {1'b0, count_value} - {1'b0, MID_SCALE};
	assign mag  = diff[CNT_W] ? (~diff + 1'b1) : diff;

	// one restoring step
	assign rem_sh  = {rem_q, dvd_q[CNT_W-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// Euclidean fix-up, then optional mirror
	assign euc     = (neg_q && (rem_q != '0)) ? (res_q - rem_q) : rem_q;
	assign pos_new = rev_q ? (res_q - euc) : euc;

	assign stat.res_zero  = (res_q == '0);
	assign stat.pp_zero   = (pp_q == '0);
	assign stat.quot_zero = (dvd_q == '0);
	assign stat.out_free  = !oval_q || out_ready;

	assign out_valid = oval_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_W'(4096);
			rev_q <= 1'b0;
			pp_q  <= PP_W'(4);
			ofs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RES: res_q <= cfg_data[RES_W-1:0];
				REG_REV: rev_q <= cfg_data[0];
				REG_PP:  pp_q  <= cfg_data[PP_W-1:0];
				REG_OFS: ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			unique case (cmd.div_op)
				OP_POS: begin
					rem_q <= '0;
					dvd_q <= mag[CNT_W-1:0];
					dvs_q <= res_q;
					neg_q <= diff[CNT_W];
				end
				OP_ELEC: begin
					rem_q <= '0;
					dvd_q <= {1'b0, res_q};
					dvs_q <= {{(RES_W-PP_W){1'b0}}, pp_q};
				end
				OP_MOD: begin
					rem_q <= '0;
					dvd_q <= {1'b0, pos_q};
					dvs_q <= dvd_q[RES_W-1:0];
				end
				OP_FRAC: begin
					dvd_q <= '0;
					dvs_q <= elec_q;
				end
				default: ;
			endcase
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[RES_W-1:0] : rem_sh[RES_W-1:0];
			dvd_q <= {dvd_q[CNT_W-2:0], ge};
		end
		if (cmd.elec_done)
			elec_q <= dvd_q[RES_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_res) begin
			reload_q <= cmd.init_reload;
			valid_q  <= cmd.init_valid;
			pos_q    <= '0;
		end
		if (cmd.pos_done)
			pos_q <= pos_new;
		// zero resolution sets the offset in the accept cycle itself
		if (cmd.ang_offs)
			angle_q <= ofs_q;
		else if (cmd.ang_frac)
			angle_q <= dvd_q + ofs_q;
		else if (cmd.init_res)
			angle_q <= '0;
		if (cmd.publish)
			odata_q <= {7'b0, angle_q, pos_q, valid_q, reload_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			oval_q <= 1'b0;
		else if (cmd.publish)
			oval_q <= 1'b1;
		else if (out_ready)
			oval_q <= 1'b0;
	end

endmodule

### rtl/encoder_marker_position_angle_unit.sv
// Incremental encoder marker/position/electrical-angle unit, top level.
// Depends on empa_pkg, empa_ctrl and empa_dp.
//
// Input stream (s_*): one item per event. s_tuser = cmd (0 marker, 1 counter
// sample). Marker items answer with reload_request when the block is marked or
// capture_busy is set; the first marker seen with capture_busy set marks the block.
// Samples taken while marked give the shaft position and electrical angle.
// Output stream (m_*): exactly one result item for every input item, in order.
// Config port: cfg_we/cfg_index/cfg_data, index 0 counts_per_turn,
// 1 reverse_direction, 2 pole_pair_count, 3 angle_offset; write only when idle.
// Flow: a marker item, an unmarked sample or a sample with zero resolution
// goes from accept straight to the publish state; the next item is taken
// after its result enters the output register. Other marked samples run up
// to four 16-step passes of one shared restoring divider (position mod,
// turn/pole split, electrical mod, fraction) before the publish state;
// fewer passes when the pole pair count or the electrical period is zero.
// The output register decouples the sides: the next item is taken while a
// finished result still waits for m_tready; a result waiting on a stalled
// receiver holds the sequencer only when the next result is ready too.
// Reset: unmarked, config registers back to 4096 / 0 / 4 / 0, no output item.
module encoder_marker_position_angle_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [0] capture_busy, [16:1] count_value, rest zero
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] reload_request, [1] position_valid,
	                               // [16:2] shaft_position, [32:17] electric_angle
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import empa_pkg::*;

	empa_cmd_t  cmd;
	empa_stat_t stat;

	// sequencer: marker state, intake, divider pass order
	empa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tuser),
		.in_busy   (s_tdata[0]),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic, config and output register
	empa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.count_value (s_tdata[CNT_W:1]),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata)
	);

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	// a marker reload and a converted position never share a result
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("reload and position both flagged");

	// unconverted results carry zero position and angle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (m_tdata[32:2] == '0))
		else $error("non-zero payload on invalid position");

	// publish only into a free output register
	a_pub: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> stat.out_free)
		else $error("result overwrote a waiting item");

endmodule
